// ----- rtl/ole_pkg.sv -----
// Shared types for the ordered list engine: request kinds and status codes.
// No dependencies.
package ole_pkg;

   typedef enum logic [2:0] {
      KIND_INS_FRONT = 3'd0,
      KIND_INS_BACK  = 3'd1,
      KIND_INS_AT    = 3'd2,
      KIND_DEL_FRONT = 3'd3,
      KIND_DEL_BACK  = 3'd4,
      KIND_DEL_AT    = 3'd5,
      KIND_SEARCH    = 3'd6,
      KIND_CLEAR     = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_POS   = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

endpackage

// ----- rtl/ole_ram.sv -----
// Entry store for the ordered list engine: one write port, one read port,
// registered read data. Depends on nothing.
module ole_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ordered_list_engine.sv -----
// Ordered list engine top level: request sequencer, entry count, result beat.
// Depends on ole_pkg and ole_ram.
//
//   channel | direction | ports                                      | handshake
//   --------+-----------+--------------------------------------------+----------------
//   req     | in        | kind, value, position                      | req_valid/stall
//   rsp     | out       | status, found_index, count                 | rsp_valid/stall
//
// Work per request, from the accept edge to the result beat:
//   clear, error cases, delete of the last entry: the result is registered on the accept edge.
//   insert at index p: entries p and up move up one place, then the value is written at p.
//   delete at p, not the last entry: the entries above p move down one place.
//   search: entries are compared from index 0 up to the first hit or the last entry.
// The cost is set by the one read port and one write port of the entry store: one entry
// is moved (read one cycle, written the next, overlapped) or compared per cycle.
// Reset is synchronous: it empties the list; entry contents are left as they are.
// A new request is taken only when the sequencer is idle and the result slot is
// empty or being drained on the same edge; rsp_stall holds the result beat.
module ordered_list_engine #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  ole_pkg::kind_type   req_kind,
   input  logic signed [31:0]  req_value,
   input  logic [6:0]          req_position,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ole_pkg::status_type rsp_status,
   output logic signed [6:0]   rsp_found_index,
   output logic [6:0]          rsp_count
);

   import ole_pkg::*;

   localparam int unsigned AW   = $clog2(CAPACITY);      // entry index width
   localparam int unsigned CW   = $clog2(CAPACITY + 1);  // entry count width
   localparam int unsigned CMPW = (CW > 7) ? CW : 7;     // position compare width
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   // One-hot sequencer states
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SHIFT  = 5'b00010,   // overlapped read/write of entries being moved
      S_LAST   = 5'b00100,   // write of the final moved entry
      S_PUT    = 5'b01000,   // write of the inserted value
      S_SEARCH = 5'b10000    // linear scan, one compare per cycle
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  rptr_ff,  rptr_in;    // next entry to read
   logic [AW-1:0]  wptr_ff,  wptr_in;    // target (or index) of data in read register
   logic [AW-1:0]  stop_ff,  stop_in;    // last entry to read in a shift
   logic [AW-1:0]  pos_ff,   pos_in;     // insert slot
   logic [31:0]    val_ff,   val_in;     // insert value or search key
   logic           grow_ff,  grow_in;    // 1: entries move up (insert)
   logic           pend_ff,  pend_in;    // read register holds a live entry

   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   logic [6:0]     rsp_found_ff;
   logic [6:0]     rsp_count_ff;

   // store port
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [31:0]    mem_wdata;
   logic [AW-1:0]  mem_raddr;
   logic [31:0]    rd_data;

   // finish of a request
   logic           fin;
   status_type     fin_status;
   logic           fin_hit;
   logic [AW-1:0]  fin_idx;

   logic           accept;
   logic           do_ins, do_del;
   logic [AW-1:0]  tgt;
   logic [CW-1:0]  cnt_m1;
   logic [AW-1:0]  last_idx;
   logic [CMPW-1:0] pos_w, cnt_w;
   logic [CW+6:0]  cnt_wide;
   logic [AW+6:0]  idx_wide;

   ole_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (32)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign cnt_m1   = count_ff - CW'(1);
   assign last_idx = cnt_m1[AW-1:0];
   assign pos_w    = CMPW'(req_position);
   assign cnt_w    = CMPW'(count_ff);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rptr_in    = rptr_ff;
      wptr_in    = wptr_ff;
      stop_in    = stop_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      grow_in    = grow_ff;
      pend_in    = pend_ff;
      fin        = 1'b0;
      fin_status = STATUS_OK;
      fin_hit    = 1'b0;
      fin_idx    = wptr_ff;
      mem_we     = 1'b0;
      mem_waddr  = wptr_ff;
      mem_wdata  = rd_data;
      mem_raddr  = rptr_ff;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      tgt        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in = req_value;
               unique case (req_kind)
                  KIND_INS_FRONT: begin
                     do_ins = 1'b1;
                     tgt    = '0;
                  end
                  KIND_INS_BACK: begin
                     do_ins = 1'b1;
                     tgt    = count_ff[AW-1:0];
                  end
                  KIND_INS_AT: begin
                     if (pos_w > cnt_w) begin
                        fin        = 1'b1;
                        fin_status = STATUS_BAD_POS;
                     end else begin
                        do_ins = 1'b1;
                        tgt    = pos_w[AW-1:0];
                     end
                  end
                  KIND_DEL_FRONT: begin
                     if (count_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = STATUS_EMPTY;
                     end else begin
                        do_del = 1'b1;
                        tgt    = '0;
                     end
                  end
                  KIND_DEL_BACK: begin
                     if (count_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = STATUS_EMPTY;
                     end else begin
                        do_del = 1'b1;
                        tgt    = last_idx;
                     end
                  end
                  KIND_DEL_AT: begin
                     if (pos_w >= cnt_w) begin
                        fin        = 1'b1;
                        fin_status = STATUS_BAD_POS;
                     end else begin
                        do_del = 1'b1;
                        tgt    = pos_w[AW-1:0];
                     end
                  end
                  KIND_SEARCH: begin
                     if (count_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = STATUS_NOT_FOUND;
                     end else begin
                        rptr_in  = '0;
                        pend_in  = 1'b0;
                        state_in = S_SEARCH;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                     fin      = 1'b1;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase

               if (do_ins) begin
                  pos_in = tgt;
                  if (count_ff == CAP_CNT) begin
                     fin        = 1'b1;
                     fin_status = STATUS_FULL;
                  end else if (count_ff == CW'(tgt)) begin
                     state_in = S_PUT;           // nothing to move
                  end else begin
                     rptr_in  = last_idx;
                     stop_in  = tgt;
                     grow_in  = 1'b1;
                     pend_in  = 1'b0;
                     state_in = S_SHIFT;
                  end
               end

               if (do_del) begin
                  if (tgt == last_idx) begin
                     count_in = cnt_m1;          // tail entry: just drop it
                     fin      = 1'b1;
                  end else begin
                     rptr_in  = tgt + AW'(1);
                     stop_in  = last_idx;
                     grow_in  = 1'b0;
                     pend_in  = 1'b0;
                     state_in = S_SHIFT;
                  end
               end
            end
         end

         S_SHIFT: begin
            // read rptr while writing the entry read on the previous cycle
            mem_we  = pend_ff;
            wptr_in = grow_ff ? (rptr_ff + AW'(1)) : (rptr_ff - AW'(1));
            pend_in = 1'b1;
            if (rptr_ff == stop_ff) begin
               state_in = S_LAST;
            end else begin
               rptr_in = grow_ff ? (rptr_ff - AW'(1)) : (rptr_ff + AW'(1));
            end
         end

         S_LAST: begin
            mem_we  = 1'b1;
            pend_in = 1'b0;
            if (grow_ff) begin
               state_in = S_PUT;
            end else begin
               count_in = cnt_m1;
               fin      = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = val_ff;
            count_in  = count_ff + CW'(1);
            fin       = 1'b1;
            state_in  = S_IDLE;
         end

         S_SEARCH: begin
            if (pend_ff && (rd_data == val_ff)) begin
               fin      = 1'b1;
               fin_hit  = 1'b1;
               fin_idx  = wptr_ff;
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end else if (pend_ff && (wptr_ff == last_idx)) begin
               fin        = 1'b1;
               fin_status = STATUS_NOT_FOUND;
               pend_in    = 1'b0;
               state_in   = S_IDLE;
            end else begin
               wptr_in = rptr_ff;
               rptr_in = rptr_ff + AW'(1);
               pend_in = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end

   // fields are reported modulo 2^7
   assign cnt_wide = {7'b0, count_in};
   assign idx_wide = {7'b0, fin_idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rptr_ff <= rptr_in;
      wptr_ff <= wptr_in;
      stop_ff <= stop_in;
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      grow_ff <= grow_in;
      if (fin) begin
         rsp_status_ff <= fin_status;
         rsp_found_ff  <= fin_hit ? idx_wide[6:0] : '1;
         rsp_count_ff  <= cnt_wide[6:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_count       = rsp_count_ff;

endmodule
